[hw/rtl/mhd_pkg.sv]
// Shared types and constants for the max-heap delete-at-index block.
package mhd_pkg;

	// Fixed widths of the channel fields
	localparam int ACT_BITS   = 2;
	localparam int POS_BITS   = 7;
	localparam int DATA_BITS  = 32;
	localparam int COUNT_BITS = 7;
	localparam int STAT_BITS  = 2;

	// Action codes; the fourth code is unused and does nothing
	typedef enum logic [ACT_BITS-1:0] {
		ACT_APPEND = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_READ   = 2'd2
	} action_t;

	// Result status codes
	typedef enum logic [STAT_BITS-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RDATA,
		S_DFETCH,
		S_UP,
		S_DOWN,
		S_PLACE,
		S_DONE
	} state_t;

	// One result transaction
	typedef struct packed {
		logic [DATA_BITS-1:0]  value_out;
		logic [COUNT_BITS-1:0] count_out;
		status_t               status;
	} res_t;

endpackage

[hw/rtl/mhd_in_if.sv]
// Input channel: one heap action per transaction.
interface mhd_in_if;
	logic                                valid;
	logic                                ready;
	logic [mhd_pkg::ACT_BITS-1:0]        action;
	logic [mhd_pkg::POS_BITS-1:0]        position;
	logic signed [mhd_pkg::DATA_BITS-1:0] value_in;

	modport source (output valid, action, position, value_in, input ready);
	modport sink (input valid, action, position, value_in, output ready);
endinterface

[hw/rtl/mhd_out_if.sv]
// Output channel: one result per transaction.
interface mhd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mhd_pkg::DATA_BITS-1:0] value_out;
	logic [mhd_pkg::COUNT_BITS-1:0]       count_out;
	logic [mhd_pkg::STAT_BITS-1:0]        status;

	modport source (output valid, value_out, count_out, status, input ready);
	modport sink (input valid, value_out, count_out, status, output ready);
endinterface

[hw/rtl/mhd_mem.sv]
// Heap storage: one write port, two read ports, registered read data.
module mhd_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] ra_addr,
	input  logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic [WIDTH-1:0]         ra_data,
	output logic [WIDTH-1:0]         rb_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read; a same-address read returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		ra_data <= mem_q[ra_addr];
		rb_data <= mem_q[rb_addr];
	end

endmodule

[hw/rtl/mhd_ctrl.sv]
// Heap controller: action decode, sift-up / sift-down sequencer, entry count.
module mhd_ctrl #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mhd_in_if.sink                      in_ch,
	output logic                        res_valid,
	input  logic                        res_ready,
	output mhd_pkg::res_t               res,
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output logic [VALUE_BITS-1:0]       mem_wdata,
	output logic [$clog2(CAPACITY)-1:0] mem_ra_addr,
	output logic [$clog2(CAPACITY)-1:0] mem_rb_addr,
	input  logic [VALUE_BITS-1:0]       mem_ra_data,
	input  logic [VALUE_BITS-1:0]       mem_rb_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int HW = CW + 1;
	localparam int PW = (CW > mhd_pkg::POS_BITS) ? CW : mhd_pkg::POS_BITS;

	// Control state
	mhd_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic            first_q, first_d;

	// Item and working registers
	mhd_pkg::action_t            act_q, act_d;
	logic [mhd_pkg::POS_BITS-1:0] pos_q, pos_d;
	logic [VALUE_BITS-1:0]       val_q, val_d;
	logic [CW-1:0]               hole_q, hole_d;
	logic [VALUE_BITS-1:0]       x_q, x_d;
	logic [VALUE_BITS-1:0]       res_value_q, res_value_d;
	mhd_pkg::status_t            res_status_q, res_status_d;

	// Helpers
	logic          pos_bad;
	logic [AW-1:0] hole_addr;
	logic [AW-1:0] pos_addr;
	logic [HW-1:0] lidx, ridx;
	logic          r_ok, take_l, take_r, moved;
	logic [VALUE_BITS-1:0] best_val, big_val;
	logic [HW-1:0] big_idx;
	logic [CW-1:0] down_idx, down_n;
	logic [HW-1:0] down_l;
	logic          down_has_child;
	logic          up_gt;

	assign pos_bad   = (pos_q == '0) || (PW'(pos_q) > PW'(count_q));
	assign hole_addr = AW'(hole_q - 1'b1);
	assign pos_addr  = AW'(pos_q - 1'b1);

	// Child selection for one sift-down level (children data arrive this cycle)
	assign lidx     = {hole_q, 1'b0};
	assign ridx     = {hole_q, 1'b1};
	assign r_ok     = ridx <= HW'(count_q);
	assign take_l   = $signed(mem_ra_data) > $signed(x_q);
	assign best_val = take_l ? mem_ra_data : x_q;
	assign take_r   = r_ok && ($signed(mem_rb_data) > $signed(best_val));
	assign moved    = take_l || take_r;
	assign big_val  = take_r ? mem_rb_data : mem_ra_data;
	assign big_idx  = take_r ? ridx : (take_l ? lidx : HW'(hole_q));

	// Parent compare for sift-up
	assign up_gt = $signed(x_q) > $signed(mem_ra_data);

	// Where the next sift-down level starts and the heap size it sees
	always_comb begin
		down_idx = hole_q;
		down_n   = count_q;
		case (state_q)
			mhd_pkg::S_DOWN:   down_idx = CW'(big_idx);
			mhd_pkg::S_DFETCH: down_n   = count_q - 1'b1;
			default: ;
		endcase
	end

	assign down_l         = {down_idx, 1'b0};
	assign down_has_child = down_l <= HW'(down_n);

	assign in_ch.ready = (state_q == mhd_pkg::S_IDLE);
	assign res_valid   = (state_q == mhd_pkg::S_DONE);

	always_comb begin
		res.value_out = mhd_pkg::DATA_BITS'(res_value_q);
		res.count_out = mhd_pkg::COUNT_BITS'(count_q);
		res.status    = res_status_q;
	end

	// Next state, memory requests and register updates
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		first_d      = first_q;
		act_d        = act_q;
		pos_d        = pos_q;
		val_d        = val_q;
		hole_d       = hole_q;
		x_d          = x_q;
		res_value_d  = res_value_q;
		res_status_d = res_status_q;
		mem_we       = 1'b0;
		mem_waddr    = hole_addr;
		mem_wdata    = x_q;
		mem_ra_addr  = hole_addr;
		mem_rb_addr  = hole_addr;

		case (state_q)
			mhd_pkg::S_IDLE: begin
				if (in_ch.valid) begin
					act_d   = mhd_pkg::action_t'(in_ch.action);
					pos_d   = in_ch.position;
					val_d   = VALUE_BITS'($unsigned(in_ch.value_in));
					state_d = mhd_pkg::S_EXEC;
				end
			end

			mhd_pkg::S_EXEC: begin
				res_value_d  = '0;
				res_status_d = mhd_pkg::STAT_OK;
				state_d      = mhd_pkg::S_DONE;
				case (act_q)
					mhd_pkg::ACT_APPEND: begin
						if (count_q == CW'(CAPACITY)) begin
							res_status_d = mhd_pkg::STAT_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = AW'(count_q);
							mem_wdata = val_q;
							count_d   = count_q + 1'b1;
						end
					end
					mhd_pkg::ACT_DELETE: begin
						if (pos_bad) begin
							res_status_d = mhd_pkg::STAT_RANGE;
						end else begin
							mem_ra_addr = pos_addr;
							mem_rb_addr = AW'(count_q - 1'b1);
							hole_d      = CW'(pos_q);
							state_d     = mhd_pkg::S_DFETCH;
						end
					end
					mhd_pkg::ACT_READ: begin
						if (pos_bad) begin
							res_status_d = mhd_pkg::STAT_RANGE;
						end else begin
							mem_ra_addr = pos_addr;
							state_d     = mhd_pkg::S_RDATA;
						end
					end
					default: ;
				endcase
			end

			mhd_pkg::S_RDATA: begin
				res_value_d = mem_ra_data;
				state_d     = mhd_pkg::S_DONE;
			end

			// Removed entry on port A, last entry on port B
			mhd_pkg::S_DFETCH: begin
				res_value_d = mem_ra_data;
				x_d         = mem_rb_data;
				count_d     = count_q - 1'b1;
				if (hole_q == count_q) begin
					state_d = mhd_pkg::S_DONE;
				end else if (hole_q != CW'(1)) begin
					mem_ra_addr = AW'((hole_q >> 1) - 1'b1);
					first_d     = 1'b1;
					state_d     = mhd_pkg::S_UP;
				end else if (down_has_child) begin
					mem_ra_addr = AW'(down_l - 1'b1);
					mem_rb_addr = AW'(down_l);
					state_d     = mhd_pkg::S_DOWN;
				end else begin
					state_d = mhd_pkg::S_PLACE;
				end
			end

			// Parent data on port A
			mhd_pkg::S_UP: begin
				first_d = 1'b0;
				if (up_gt) begin
					mem_we    = 1'b1;
					mem_wdata = mem_ra_data;
					hole_d    = hole_q >> 1;
					if ((hole_q >> 1) != CW'(1)) begin
						mem_ra_addr = AW'((hole_q >> 2) - 1'b1);
						state_d     = mhd_pkg::S_UP;
					end else begin
						state_d = mhd_pkg::S_PLACE;
					end
				end else if (first_q && down_has_child) begin
					mem_ra_addr = AW'(down_l - 1'b1);
					mem_rb_addr = AW'(down_l);
					state_d     = mhd_pkg::S_DOWN;
				end else begin
					state_d = mhd_pkg::S_PLACE;
				end
			end

			// Children data on ports A and B
			mhd_pkg::S_DOWN: begin
				if (!moved) begin
					state_d = mhd_pkg::S_PLACE;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = big_val;
					hole_d    = CW'(big_idx);
					if (down_has_child) begin
						mem_ra_addr = AW'(down_l - 1'b1);
						mem_rb_addr = AW'(down_l);
						state_d     = mhd_pkg::S_DOWN;
					end else begin
						state_d = mhd_pkg::S_PLACE;
					end
				end
			end

			mhd_pkg::S_PLACE: begin
				mem_we  = 1'b1;
				state_d = mhd_pkg::S_DONE;
			end

			mhd_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = mhd_pkg::S_IDLE;
				end
			end

			default: state_d = mhd_pkg::S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhd_pkg::S_IDLE;
			count_q <= '0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			first_q <= first_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		act_q        <= act_d;
		pos_q        <= pos_d;
		val_q        <= val_d;
		hole_q       <= hole_d;
		x_q          <= x_d;
		res_value_q  <= res_value_d;
		res_status_q <= res_status_d;
	end

	// Count never passes capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// The hole under sift stays inside the live heap
	a_hole_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mhd_pkg::S_UP || state_q == mhd_pkg::S_DOWN ||
		 state_q == mhd_pkg::S_PLACE) |-> (hole_q != '0 && hole_q <= count_q))
		else $error("sift hole outside heap");

	// A delete drops the count by exactly one
	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mhd_pkg::S_DFETCH |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("delete did not decrement count");

	// Sift-up only runs below the root
	a_up_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mhd_pkg::S_UP |-> hole_q > CW'(1))
		else $error("sift-up at root");

endmodule

[hw/rtl/max_heap_delete_at_index.sv]
// Top level of the max-heap with delete at an arbitrary position.
//
//  channel  | dir | payload                           | handshake
//  ---------+-----+-----------------------------------+-------------
//  in_ch    | in  | action, position, value_in        | valid/ready
//  out_ch   | out | value_out, count_out, status      | valid/ready
//
// One transaction at a time. Append, the unused code and errors finish in the
// execute state; a read and a delete of the last entry fetch from storage; any
// other delete sifts the last entry up or down through at most log2(CAPACITY) - 1
// compare levels (5 at the default), one read-compare-write per level against the
// storage, then places it. The finished result sits in an output register so a
// new transaction is taken while it waits; a full, stalled output register holds
// the controller in its done state. Reset clears the count and the controller;
// the storage is not cleared, only live entries are read.
module max_heap_delete_at_index #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	mhd_in_if.sink     in_ch,
	mhd_out_if.source  out_ch
);

	localparam int AW = $clog2(CAPACITY);

	logic                  res_valid;
	logic                  res_ready;
	mhd_pkg::res_t         res;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [VALUE_BITS-1:0] mem_wdata;
	logic [AW-1:0]         mem_ra_addr;
	logic [AW-1:0]         mem_rb_addr;
	logic [VALUE_BITS-1:0] mem_ra_data;
	logic [VALUE_BITS-1:0] mem_rb_data;

	logic          out_valid_q;
	mhd_pkg::res_t out_res_q;

	mhd_ctrl #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_ra_addr (mem_ra_addr),
		.mem_rb_addr (mem_rb_addr),
		.mem_ra_data (mem_ra_data),
		.mem_rb_data (mem_rb_data)
	);

	mhd_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_BITS)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.ra_addr (mem_ra_addr),
		.rb_addr (mem_rb_addr),
		.ra_data (mem_ra_data),
		.rb_data (mem_rb_data)
	);

	// Output register: loads when empty or being drained
	assign res_ready = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.value_out = $signed(out_res_q.value_out);
	assign out_ch.count_out = out_res_q.count_out;
	assign out_ch.status    = out_res_q.status;

endmodule
